[rtl/binary_heap_priority_queue_top_macros.svh]
// Assertion macros for the priority queue checker.
// Used by bhpq_checker.sv; expects signals named clock and reset in scope.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define BHPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define BHPQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/bhpq_pkg.sv]
// Package for the priority queue: command and status codes, default sizes
// and the control word driven into the row of cells. No dependencies.
`timescale 1ns / 1ps

package bhpq_pkg;

   localparam int DEF_CAPACITY       = 64;
   localparam int DEF_VALUE_WIDTH    = 32;
   localparam int DEF_PRIORITY_WIDTH = 32;
   localparam int DEF_STAMP_WIDTH    = 32;

   localparam int FIELD_WIDTH = 32;
   localparam int ECOUNT_WIDTH = 7;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_PEEK   = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic ins;
      logic rem;
   } bhpq_ctrl_type;

endpackage

[rtl/bhpq_cell.sv]
// One cell of the sorted row: holds one entry and moves it left or right.
// Depends on bhpq_pkg for the control word.
`timescale 1ns / 1ps

module bhpq_cell import bhpq_pkg::*; #(
   parameter int IDX            = 0,
   parameter int CAPACITY       = DEF_CAPACITY,
   parameter int VALUE_WIDTH    = DEF_VALUE_WIDTH,
   parameter int PRIORITY_WIDTH = DEF_PRIORITY_WIDTH,
   parameter int STAMP_WIDTH    = DEF_STAMP_WIDTH,
   localparam int COUNT_W       = $clog2(CAPACITY + 1)
) (
   input  logic                      clock,
   input  bhpq_ctrl_type             ctrl,
   input  logic [COUNT_W-1:0]        fill,
   input  logic [VALUE_WIDTH-1:0]    new_value,
   input  logic [PRIORITY_WIDTH-1:0] new_key,
   input  logic [STAMP_WIDTH-1:0]    new_stamp,
   input  logic                      left_ahead,
   input  logic [VALUE_WIDTH-1:0]    left_value,
   input  logic [PRIORITY_WIDTH-1:0] left_key,
   input  logic [STAMP_WIDTH-1:0]    left_stamp,
   input  logic [VALUE_WIDTH-1:0]    right_value,
   input  logic [PRIORITY_WIDTH-1:0] right_key,
   input  logic [STAMP_WIDTH-1:0]    right_stamp,
   output logic                      ahead,
   output logic [VALUE_WIDTH-1:0]    value,
   output logic [PRIORITY_WIDTH-1:0] key,
   output logic [STAMP_WIDTH-1:0]    stamp
);

   logic [VALUE_WIDTH-1:0]    value_ff, value_in;
   logic [PRIORITY_WIDTH-1:0] key_ff, key_in;
   logic [STAMP_WIDTH-1:0]    stamp_ff, stamp_in;
   logic                      occupied;

   assign occupied = COUNT_W'(IDX) < fill;

   // The new word goes ahead of this entry when it wins, or when the cell is empty.
   assign ahead = !occupied || (new_key < key_ff) ||
                  ((new_key == key_ff) && (new_stamp < stamp_ff));

   always_comb begin
      value_in = value_ff;
      key_in   = key_ff;
      stamp_in = stamp_ff;
      if (ctrl.ins) begin
         if (left_ahead) begin
            value_in = left_value;
            key_in   = left_key;
            stamp_in = left_stamp;
         end else if (ahead) begin
            value_in = new_value;
            key_in   = new_key;
            stamp_in = new_stamp;
         end
      end else if (ctrl.rem) begin
         value_in = right_value;
         key_in   = right_key;
         stamp_in = right_stamp;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      key_ff   <= key_in;
      stamp_ff <= stamp_in;
   end

   assign value = value_ff;
   assign key   = key_ff;
   assign stamp = stamp_ff;

endmodule

[rtl/binary_heap_priority_queue_top.sv]
// Top level of the priority queue: request latch, fill and arrival counters,
// result register and the row of bhpq_cell instances. Depends on bhpq_pkg.
`timescale 1ns / 1ps

// Usage
// A command word is taken at a rising edge with start high and busy low.
// Insert adds value and priority, remove takes the winning entry and peek
// reads it; a smaller priority wins and on a tie the earlier arrival wins.
// The entries sit sorted in a row of cells, the winner in the first cell.
// An insert is placed by every cell comparing itself with the new word and
// shifting right; a remove shifts every cell left by one. The word is
// latched when taken and executed while busy is high; the result follows
// on the rsp_ ports in the cycle after that, marked by rsp_strobe for
// exactly one cycle. A new command is taken only while busy is low, which
// it is again in the cycle in which the result is shown.
// The receiver cannot stall, so the result is simply shown and dropped.
// Reset empties the queue, clears the arrival stamp and cancels any word in
// flight. Insert into a full queue returns full status, remove or peek on
// an empty queue returns empty status, both leaving the contents as they are.

module binary_heap_priority_queue_top import bhpq_pkg::*; #(
   parameter int CAPACITY       = DEF_CAPACITY,
   parameter int VALUE_WIDTH    = DEF_VALUE_WIDTH,
   parameter int PRIORITY_WIDTH = DEF_PRIORITY_WIDTH,
   parameter int STAMP_WIDTH    = DEF_STAMP_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_command,
   input  logic signed [FIELD_WIDTH-1:0] req_in_value,
   input  logic signed [FIELD_WIDTH-1:0] req_in_priority,
   output logic                          rsp_strobe,
   output logic signed [FIELD_WIDTH-1:0] rsp_out_value,
   output logic [1:0]                    rsp_status,
   output logic [ECOUNT_WIDTH-1:0]       rsp_entry_count
);

   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int VX      = (VALUE_WIDTH > FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;
   localparam int PX      = (PRIORITY_WIDTH > FIELD_WIDTH) ? PRIORITY_WIDTH : FIELD_WIDTH;
   localparam int CX      = (COUNT_W > ECOUNT_WIDTH) ? COUNT_W : ECOUNT_WIDTH;

   logic                      pend_ff, pend_in;
   logic [1:0]                cmd_ff;
   logic [VALUE_WIDTH-1:0]    val_ff, val_in;
   logic [PRIORITY_WIDTH-1:0] key_ff, key_in;
   logic [COUNT_W-1:0]        fill_ff, fill_in;
   logic [STAMP_WIDTH-1:0]    arr_ff, arr_in;
   logic                      strobe_ff;
   logic [FIELD_WIDTH-1:0]    out_value_ff, out_value_in;
   logic [1:0]                status_ff, status_in;
   logic [ECOUNT_WIDTH-1:0]   count_ff;
   logic [CX-1:0]             count_wide;
   logic [VX-1:0]             val_ext, root_ext;
   logic [PX-1:0]             prio_ext;
   logic                      accept;
   bhpq_ctrl_type             ctrl;

   logic                      c_ahead  [CAPACITY];
   logic [VALUE_WIDTH-1:0]    c_value  [CAPACITY];
   logic [PRIORITY_WIDTH-1:0] c_key    [CAPACITY];
   logic [STAMP_WIDTH-1:0]    c_stamp  [CAPACITY];

   assign accept = start && !busy;
   assign busy   = pend_ff;

   // Fields arrive as 32-bit signed numbers; the key flips the sign bit so
   // that an unsigned compare orders priorities as signed ones.
   assign val_ext  = VX'(req_in_value);
   assign prio_ext = PX'(req_in_priority);
   assign val_in   = val_ext[VALUE_WIDTH-1:0];
   assign key_in   = prio_ext[PRIORITY_WIDTH-1:0] ^
                     (PRIORITY_WIDTH'(1) << (PRIORITY_WIDTH - 1));

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         val_ff <= val_in;
         key_ff <= key_in;
      end
   end

   assign root_ext = VX'(c_value[0]);

   always_comb begin
      pend_in      = accept;
      ctrl         = '0;
      fill_in      = fill_ff;
      arr_in       = arr_ff;
      status_in    = STATUS_OK;
      out_value_in = '0;
      if (pend_ff) begin
         case (cmd_ff)
            CMD_INSERT: begin
               if (fill_ff == COUNT_W'(CAPACITY)) begin
                  status_in = STATUS_FULL;
               end else begin
                  ctrl.ins = 1'b1;
                  fill_in  = fill_ff + COUNT_W'(1);
                  arr_in   = arr_ff + STAMP_WIDTH'(1);
               end
            end
            CMD_REMOVE, CMD_PEEK: begin
               if (fill_ff == '0) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  out_value_in = root_ext[FIELD_WIDTH-1:0];
                  if (cmd_ff == CMD_REMOVE) begin
                     ctrl.rem = 1'b1;
                     fill_in  = fill_ff - COUNT_W'(1);
                  end
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   assign count_wide = CX'(fill_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 1'b0;
         fill_ff   <= '0;
         arr_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         pend_ff   <= pend_in;
         fill_ff   <= fill_in;
         arr_ff    <= arr_in;
         strobe_ff <= pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         out_value_ff <= out_value_in;
         status_ff    <= status_in;
         count_ff     <= count_wide[ECOUNT_WIDTH-1:0];
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      l_ahead;
      logic [VALUE_WIDTH-1:0]    l_value, r_value;
      logic [PRIORITY_WIDTH-1:0] l_key, r_key;
      logic [STAMP_WIDTH-1:0]    l_stamp, r_stamp;

      if (i == 0) begin : g_first
         assign l_ahead  = 1'b0;
         assign l_value  = val_ff;
         assign l_key    = key_ff;
         assign l_stamp  = arr_ff;
      end else begin : g_inner
         assign l_ahead  = c_ahead[i-1];
         assign l_value  = c_value[i-1];
         assign l_key    = c_key[i-1];
         assign l_stamp  = c_stamp[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign r_value = val_ff;
         assign r_key   = key_ff;
         assign r_stamp = arr_ff;
      end else begin : g_link
         assign r_value = c_value[i+1];
         assign r_key   = c_key[i+1];
         assign r_stamp = c_stamp[i+1];
      end

      bhpq_cell #(
         .IDX            (i),
         .CAPACITY       (CAPACITY),
         .VALUE_WIDTH    (VALUE_WIDTH),
         .PRIORITY_WIDTH (PRIORITY_WIDTH),
         .STAMP_WIDTH    (STAMP_WIDTH)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .fill        (fill_ff),
         .new_value   (val_ff),
         .new_key     (key_ff),
         .new_stamp   (arr_ff),
         .left_ahead  (l_ahead),
         .left_value  (l_value),
         .left_key    (l_key),
         .left_stamp  (l_stamp),
         .right_value (r_value),
         .right_key   (r_key),
         .right_stamp (r_stamp),
         .ahead       (c_ahead[i]),
         .value       (c_value[i]),
         .key         (c_key[i]),
         .stamp       (c_stamp[i])
      );
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_out_value   = signed'(out_value_ff);
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ff;

endmodule

[rtl/bhpq_checker.sv]
// Port-level checker for the priority queue, bound to the top level.
// Depends on bhpq_pkg and binary_heap_priority_queue_top_macros.svh.
`timescale 1ns / 1ps
`include "binary_heap_priority_queue_top_macros.svh"

module bhpq_checker import bhpq_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic signed [FIELD_WIDTH-1:0] rsp_out_value,
   input logic [1:0]                    rsp_status
);

   `BHPQ_ASSERT(a_busy_after_accept, (start && !busy) |=> busy, "busy low after accept")
   `BHPQ_ASSERT(a_result_follows, (start && !busy) |-> ##2 rsp_strobe, "result missing")
   `BHPQ_ASSERT(a_no_stray_result, rsp_strobe |-> ($past(start && !busy, 2) && !busy), "stray result")
   `BHPQ_ASSERT(a_fail_zero_value, (rsp_strobe && (rsp_status != STATUS_OK)) |-> (rsp_out_value == 0), "value set")
   `BHPQ_ASSERT_ALWAYS(a_reset_idle, reset |=> (!busy && !rsp_strobe), "block not idle after reset")

endmodule

bind binary_heap_priority_queue_top bhpq_checker u_bhpq_checker (.*);

[dv/tb_binary_heap_priority_queue_top.sv]
// Self-checking testbench for binary_heap_priority_queue_top: directed words, then random
// command sequences, each result checked against a behavioural heap held in the bench, or
// a fixed one in the plan table. Depends on bhpq_pkg and the RTL of the queue.
`timescale 1ns / 1ps

module tb_binary_heap_priority_queue_top;
   import bhpq_pkg::*;

   localparam int HEAP_DEPTH = DEF_CAPACITY;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CHUNK_WORDS = 50;
   localparam int CHUNKS = 13;
   localparam int MAX_GAP = 6;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PLAN_ROWS = 20;

   typedef enum int {PRIO_TIES, PRIO_EXTREMES, PRIO_SPREAD} prio_style_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] value;
      logic signed [FIELD_WIDTH-1:0] prio;
      logic [DEF_STAMP_WIDTH-1:0]    stamp;
   } heap_entry_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] out_value;
      logic [1:0]                    status;
      logic [ECOUNT_WIDTH-1:0]       entry_count;
   } queue_result_type;

   typedef struct packed {
      logic [1:0]                    command;
      logic signed [FIELD_WIDTH-1:0] value;
      logic signed [FIELD_WIDTH-1:0] prio;
      int                            reps;
      bit                            random_fields;
      bit                            typed;
      queue_result_type              result;
   } plan_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [1:0]                    req_command = CMD_INSERT;
   logic signed [FIELD_WIDTH-1:0] req_in_value = '0;
   logic signed [FIELD_WIDTH-1:0] req_in_priority = '0;
   logic                          rsp_strobe;
   logic signed [FIELD_WIDTH-1:0] rsp_out_value;
   logic [1:0]                    rsp_status;
   logic [ECOUNT_WIDTH-1:0]       rsp_entry_count;

   heap_entry_type         heap_model [HEAP_DEPTH];
   int                     heap_fill = 0;
   logic [DEF_STAMP_WIDTH-1:0] next_stamp = '0;
   queue_result_type       pending_results [$];
   int                     error_count = 0;
   int                     quiet_cycles = 0;

   binary_heap_priority_queue_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_in_value    (req_in_value),
      .req_in_priority (req_in_priority),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_value   (rsp_out_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit entry_beats(input heap_entry_type a, input heap_entry_type b);
      if ($signed(a.prio) == $signed(b.prio)) return a.stamp < b.stamp;
      return $signed(a.prio) < $signed(b.prio);
   endfunction

   function automatic queue_result_type heap_execute(input logic [1:0] command,
         input logic signed [FIELD_WIDTH-1:0] value,
         input logic signed [FIELD_WIDTH-1:0] prio);
      queue_result_type res;
      heap_entry_type   tmp;
      int               pos;
      int               parent;
      int               best;
      int               child;
      bit               moving;
      res = '0;
      res.status = STATUS_OK;
      case (command)
         CMD_INSERT: begin
            if (heap_fill >= HEAP_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               pos = heap_fill;
               heap_model[pos] = '{value: value, prio: prio, stamp: next_stamp};
               next_stamp = next_stamp + 1'b1;
               heap_fill++;
               while (pos > 0) begin
                  parent = (pos - 1) / 2;
                  if (!entry_beats(heap_model[pos], heap_model[parent])) break;
                  tmp = heap_model[pos];
                  heap_model[pos] = heap_model[parent];
                  heap_model[parent] = tmp;
                  pos = parent;
               end
            end
         end
         CMD_REMOVE, CMD_PEEK: begin
            if (heap_fill == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.out_value = heap_model[0].value;
               if (command == CMD_REMOVE) begin
                  heap_fill--;
                  heap_model[0] = heap_model[heap_fill];
                  pos = 0;
                  moving = 1'b1;
                  while (moving) begin
                     best = pos;
                     for (child = 2 * pos + 1; child <= 2 * pos + 2; child++) begin
                        if (child < heap_fill && entry_beats(heap_model[child], heap_model[best]))
                           best = child;
                     end
                     moving = (best != pos);
                     tmp = heap_model[pos];
                     heap_model[pos] = heap_model[best];
                     heap_model[best] = tmp;
                     pos = best;
                  end
               end
            end
         end
         default: ;
      endcase
      res.entry_count = heap_fill[ECOUNT_WIDTH-1:0];
      return res;
   endfunction

   function automatic logic signed [FIELD_WIDTH-1:0] draw_priority(input prio_style_type style);
      case (style)
         PRIO_TIES: return $signed($urandom_range(7, 0)) - 4;
         PRIO_EXTREMES: begin
            case ($urandom_range(3, 0))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return -1;
               default: return 0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input logic [1:0] command,
         input logic signed [FIELD_WIDTH-1:0] value,
         input logic signed [FIELD_WIDTH-1:0] prio, input int gap,
         input bit typed, input queue_result_type typed_result);
      queue_result_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= command;
      req_in_value <= value;
      req_in_priority <= prio;
      do @(posedge clock); while (busy);
      predicted = heap_execute(command, value, prio);
      pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
   endtask

   initial begin
      plan_row_type   plan [PLAN_ROWS];
      int             row;
      int             rep;
      int             chunk;
      int             k;
      int             ins_pct;
      int             pick;
      bit             idling;
      prio_style_type style;
      logic [1:0]     command;
      logic signed [FIELD_WIDTH-1:0] value;
      logic signed [FIELD_WIDTH-1:0] prio;

      plan = '{
         '{CMD_PEEK,   32'sd0, 32'sd0, 1, 1'b0, 1'b1, '{32'sd0, STATUS_EMPTY, 7'd0}},
         '{CMD_REMOVE, 32'sd0, 32'sd0, 1, 1'b0, 1'b1, '{32'sd0, STATUS_EMPTY, 7'd0}},
         '{CMD_UNUSED, 32'sd9, 32'sd9, 1, 1'b0, 1'b1, '{32'sd0, STATUS_OK, 7'd0}},
         '{CMD_INSERT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 1'b0, 1'b1,
           '{32'sd0, STATUS_OK, 7'd1}},
         '{CMD_INSERT, 32'sh8000_0000, 32'sh8000_0000, 1, 1'b0, 1'b1,
           '{32'sd0, STATUS_OK, 7'd2}},
         '{CMD_PEEK,   32'sd0, 32'sd0, 1, 1'b0, 1'b1, '{32'sh8000_0000, STATUS_OK, 7'd2}},
         '{CMD_INSERT, 32'sd5, 32'sh8000_0000, 1, 1'b0, 1'b1, '{32'sd0, STATUS_OK, 7'd3}},
         '{CMD_REMOVE, 32'sd0, 32'sd0, 1, 1'b0, 1'b1, '{32'sh8000_0000, STATUS_OK, 7'd2}},
         '{CMD_REMOVE, 32'sd0, 32'sd0, 1, 1'b0, 1'b1, '{32'sd5, STATUS_OK, 7'd1}},
         '{CMD_REMOVE, 32'sd0, 32'sd0, 1, 1'b0, 1'b1, '{32'sh7FFF_FFFF, STATUS_OK, 7'd0}},
         '{CMD_INSERT, 32'sd11, 32'sd0, 1, 1'b0, 1'b0, '0},
         '{CMD_INSERT, 32'sd22, 32'sd0, 1, 1'b0, 1'b0, '0},
         '{CMD_INSERT, 32'sd33, 32'sd0, 1, 1'b0, 1'b0, '0},
         '{CMD_REMOVE, 32'sd0, 32'sd0, 3, 1'b0, 1'b0, '0},
         '{CMD_INSERT, 32'sd0, 32'sd0, HEAP_DEPTH, 1'b1, 1'b0, '0},
         '{CMD_INSERT, 32'sd1, 32'sd1, 1, 1'b0, 1'b1, '{32'sd0, STATUS_FULL, 7'd64}},
         '{CMD_UNUSED, 32'sd0, 32'sd0, 1, 1'b0, 1'b1, '{32'sd0, STATUS_OK, 7'd64}},
         '{CMD_PEEK,   32'sd0, 32'sd0, 1, 1'b0, 1'b0, '0},
         '{CMD_REMOVE, 32'sd0, 32'sd0, HEAP_DEPTH, 1'b0, 1'b0, '0},
         '{CMD_REMOVE, 32'sd0, 32'sd0, 1, 1'b0, 1'b1, '{32'sd0, STATUS_EMPTY, 7'd0}}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < PLAN_ROWS; row++) begin
         for (rep = 0; rep < plan[row].reps; rep++) begin
            value = plan[row].random_fields ? $signed($urandom) : plan[row].value;
            prio = plan[row].random_fields ? draw_priority(PRIO_TIES) : plan[row].prio;
            send_word(plan[row].command, value, prio, $urandom_range(MAX_GAP, 0),
                      plan[row].typed, plan[row].result);
         end
      end

      // Each chunk leans towards filling, draining or holding the heap, so the fill level
      // wanders between empty and full with varied priority mixes.
      for (chunk = 0; chunk < CHUNKS; chunk++) begin
         case ($urandom_range(2, 0))
            0: ins_pct = 85;
            1: ins_pct = 50;
            default: ins_pct = 20;
         endcase
         style = prio_style_type'($urandom_range(2, 0));
         idling = ($urandom_range(3, 0) != 0);
         for (k = 0; k < CHUNK_WORDS; k++) begin
            pick = $urandom_range(99, 0);
            if (pick < 3) command = CMD_UNUSED;
            else if (pick < ins_pct) command = CMD_INSERT;
            else command = ($urandom_range(3, 0) == 0) ? CMD_PEEK : CMD_REMOVE;
            send_word(command, $signed($urandom), draw_priority(style),
                      idling ? $urandom_range(MAX_GAP, 0) : 0, 1'b0, '0);
         end
      end

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_binary_heap_priority_queue_top: done, clean");
      end else begin
         $display("tb_binary_heap_priority_queue_top: done, errors");
      end
      $finish;
   end

   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("result word with none expected: value %0d status %0d count %0d",
                   rsp_out_value, rsp_status, rsp_entry_count);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_value !== want.out_value) begin
               $error("out_value: expected %0d, got %0d", want.out_value, rsp_out_value);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_binary_heap_priority_queue_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
